// File: design/i2cseq_pkg.sv
package i2cseq_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BEGIN = 2'd1,
    MODE_EVENT = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_CREAD  = 2'd2,
    KIND_CWRITE = 2'd3
  } kind_t;

  localparam logic [2:0] EV_START_SENT = 3'd0;
  localparam logic [2:0] EV_ADDR_ACK_TX = 3'd1;
  localparam logic [2:0] EV_ADDR_ACK_RX = 3'd2;
  localparam logic [2:0] EV_TX_EMPTY = 3'd3;
  localparam logic [2:0] EV_BYTE_DONE = 3'd4;
  localparam logic [2:0] EV_BYTE_RCVD = 3'd5;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ADDR   = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_RSTART = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_DONE   = 3'd5,
    ACT_ERROR  = 3'd6
  } action_t;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_START   = 8'b0000_0010,
    PH_ADDR    = 8'b0000_0100,
    PH_CMD     = 8'b0000_1000,
    PH_RESTART = 8'b0001_0000,
    PH_ADDR2   = 8'b0010_0000,
    PH_RXDATA  = 8'b0100_0000,
    PH_TXDATA  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] transfer_kind;
    logic [6:0] device_address;
    logic [7:0] command_byte;
    logic [7:0] byte_count;
    logic [2:0] bus_event;
    logic       bus_fault;
    logic [7:0] data_value;
    logic [7:0] load_index;
  } item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] bus_byte;
    logic [7:0] received_byte;
    logic [7:0] received_index;
    logic       received_valid;
    logic       busy_res;
  } res_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_pos;
  } buf_req_t;

endpackage

// File: design/i2cseq_txbuf.sv
module i2cseq_txbuf #(
  parameter int TX_DEPTH = 256
) (
  input  logic                 clk,
  input  i2cseq_pkg::buf_req_t req,
  output logic [7:0]           rd_data
);

  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(TX_DEPTH);

  logic [7:0] mem [TX_DEPTH];
  logic [7:0] data_r;
  logic       oor_r;
  logic       wr_ok;
  logic       rd_ok;

  assign wr_ok = req.wr_en && ({1'b0, req.wr_addr} < DEPTH9);
  assign rd_ok = {1'b0, req.rd_pos} < DEPTH9;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // prefetch the next transmit byte, forwarding a load to the same slot
  always_ff @(posedge clk) begin
    if (wr_ok && (req.wr_addr == req.rd_pos)) begin
      data_r <= req.wr_data;
    end else begin
      data_r <= mem[req.rd_pos[AW-1:0]];
    end
    oor_r <= !rd_ok;
  end

  assign rd_data = oor_r ? 8'd0 : data_r;

endmodule

// File: design/i2cseq_core.sv
module i2cseq_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  i2cseq_pkg::item_t     item,
  input  logic [7:0]            tx_data,
  output i2cseq_pkg::res_t      res,
  output i2cseq_pkg::buf_req_t  buf_req
);

  i2cseq_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] cnt_inc;
  logic       bad;

  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    bad       = 1'b0;
    res       = '0;
    res.action = i2cseq_pkg::ACT_NONE;

    unique case (i2cseq_pkg::mode_t'(item.mode)) inside
      i2cseq_pkg::MODE_LOAD, i2cseq_pkg::MODE_NOP: begin
      end
      i2cseq_pkg::MODE_BEGIN: begin
        if (phase_r != i2cseq_pkg::PH_IDLE) begin
          bad = 1'b1;
        end else begin
          kind_nxt  = item.transfer_kind;
          addr_nxt  = item.device_address;
          cmd_nxt   = item.command_byte;
          len_nxt   = item.byte_count;
          cnt_nxt   = 8'd0;
          phase_nxt = i2cseq_pkg::PH_START;
        end
      end
      i2cseq_pkg::MODE_EVENT: begin
        if (item.bus_fault) begin
          bad = 1'b1;
        end else begin
          unique case (phase_r)
            i2cseq_pkg::PH_START: begin
              if (item.bus_event == i2cseq_pkg::EV_START_SENT) begin
                res.action   = i2cseq_pkg::ACT_ADDR;
                res.bus_byte = {addr_r, kind_r == i2cseq_pkg::KIND_READ};
                phase_nxt    = i2cseq_pkg::PH_ADDR;
              end else begin
                bad = 1'b1;
              end
            end
            i2cseq_pkg::PH_ADDR: begin
              if (kind_r == i2cseq_pkg::KIND_READ &&
                  item.bus_event == i2cseq_pkg::EV_ADDR_ACK_RX) begin
                cnt_nxt = 8'd0;
                if (len_r == 8'd0) begin
                  res.action = i2cseq_pkg::ACT_STOP;
                  phase_nxt  = i2cseq_pkg::PH_IDLE;
                end else begin
                  phase_nxt = i2cseq_pkg::PH_RXDATA;
                end
              end else if (kind_r != i2cseq_pkg::KIND_READ &&
                           item.bus_event == i2cseq_pkg::EV_ADDR_ACK_TX) begin
                if (kind_r == i2cseq_pkg::KIND_WRITE) begin
                  if (len_r == 8'd0) begin
                    res.action = i2cseq_pkg::ACT_STOP;
                    phase_nxt  = i2cseq_pkg::PH_IDLE;
                  end else begin
                    // counter is still zero here, so the prefetch holds slot zero
                    res.action   = i2cseq_pkg::ACT_DATA;
                    res.bus_byte = tx_data;
                    cnt_nxt      = 8'd1;
                    phase_nxt    = i2cseq_pkg::PH_TXDATA;
                  end
                end else begin
                  res.action   = i2cseq_pkg::ACT_DATA;
                  res.bus_byte = cmd_r;
                  cnt_nxt      = 8'd0;
                  phase_nxt    = (kind_r == i2cseq_pkg::KIND_CREAD) ?
                                 i2cseq_pkg::PH_CMD : i2cseq_pkg::PH_TXDATA;
                end
              end else begin
                bad = 1'b1;
              end
            end
            i2cseq_pkg::PH_CMD: begin
              if (item.bus_event == i2cseq_pkg::EV_BYTE_DONE) begin
                res.action = i2cseq_pkg::ACT_RSTART;
                phase_nxt  = i2cseq_pkg::PH_RESTART;
              end else begin
                bad = 1'b1;
              end
            end
            i2cseq_pkg::PH_RESTART: begin
              if (item.bus_event == i2cseq_pkg::EV_START_SENT) begin
                res.action   = i2cseq_pkg::ACT_ADDR;
                res.bus_byte = {addr_r, 1'b1};
                phase_nxt    = i2cseq_pkg::PH_ADDR2;
              end else begin
                bad = 1'b1;
              end
            end
            i2cseq_pkg::PH_ADDR2: begin
              if (item.bus_event == i2cseq_pkg::EV_ADDR_ACK_RX) begin
                cnt_nxt = 8'd0;
                if (len_r == 8'd0) begin
                  res.action = i2cseq_pkg::ACT_STOP;
                  phase_nxt  = i2cseq_pkg::PH_IDLE;
                end else begin
                  phase_nxt = i2cseq_pkg::PH_RXDATA;
                end
              end else begin
                bad = 1'b1;
              end
            end
            i2cseq_pkg::PH_RXDATA: begin
              if (item.bus_event == i2cseq_pkg::EV_BYTE_RCVD) begin
                res.received_valid = 1'b1;
                res.received_byte  = item.data_value;
                res.received_index = cnt_r;
                cnt_nxt            = cnt_inc;
                if (cnt_inc >= len_r) begin
                  res.action = i2cseq_pkg::ACT_DONE;
                  phase_nxt  = i2cseq_pkg::PH_IDLE;
                end
              end else begin
                bad = 1'b1;
              end
            end
            i2cseq_pkg::PH_TXDATA: begin
              if (item.bus_event == i2cseq_pkg::EV_TX_EMPTY ||
                  item.bus_event == i2cseq_pkg::EV_BYTE_DONE) begin
                if (cnt_r < len_r) begin
                  res.action   = i2cseq_pkg::ACT_DATA;
                  res.bus_byte = tx_data;
                  cnt_nxt      = cnt_inc;
                end else if (item.bus_event == i2cseq_pkg::EV_BYTE_DONE) begin
                  res.action = i2cseq_pkg::ACT_DONE;
                  phase_nxt  = i2cseq_pkg::PH_IDLE;
                end
              end else begin
                bad = 1'b1;
              end
            end
            default: begin
              bad = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (bad) begin
      res       = '0;
      res.action = i2cseq_pkg::ACT_ERROR;
      phase_nxt = i2cseq_pkg::PH_IDLE;
    end
    res.busy_res = (phase_nxt != i2cseq_pkg::PH_IDLE);
  end

  always_comb begin
    buf_req.wr_en   = adv && (item.mode == i2cseq_pkg::MODE_LOAD);
    buf_req.wr_addr = item.load_index;
    buf_req.wr_data = item.data_value;
    // prefetch the slot the counter will point at after this edge
    if (!rst_n) begin
      buf_req.rd_pos = 8'd0;
    end else if (adv) begin
      buf_req.rd_pos = cnt_nxt;
    end else begin
      buf_req.rd_pos = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cseq_pkg::PH_IDLE;
      kind_r  <= 2'd0;
      addr_r  <= 7'd0;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_begin_starts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.mode == i2cseq_pkg::MODE_BEGIN && phase_r == i2cseq_pkg::PH_IDLE
    |=> phase_r == i2cseq_pkg::PH_START)
    else $error("begin from idle did not enter start phase");

  a_error_idles: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.action == i2cseq_pkg::ACT_ERROR |=> phase_r == i2cseq_pkg::PH_IDLE)
    else $error("error did not return to idle");

  a_load_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.mode == i2cseq_pkg::MODE_LOAD |=> $stable(phase_r))
    else $error("load request changed phase");

endmodule

// File: design/i2c_master_transaction_sequencer_unit.sv
// A request accepted into the input register moves on to the result register once
// that register is empty or is being drained by out_ready.
// Throughput: one request per cycle, sustained; the input register refills
// while the result register drains, so only out_ready stalls the block.
// Transmit bytes are prefetched from the buffer into a register before use.
// Reset (rst_n low, synchronous) empties both registers and returns to idle;
// the transmit buffer keeps no reset and holds undefined data until loaded.
module i2c_master_transaction_sequencer_unit #(
  parameter int TX_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_transfer_kind,
  input  logic [6:0] in_device_address,
  input  logic [7:0] in_command_byte,
  input  logic [7:0] in_byte_count,
  input  logic [2:0] in_bus_event,
  input  logic       in_bus_fault,
  input  logic [7:0] in_data_value,
  input  logic [7:0] in_load_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [7:0] out_bus_byte,
  output logic [7:0] out_received_byte,
  output logic [7:0] out_received_index,
  output logic       out_received_valid,
  output logic       out_busy_res
);

  i2cseq_pkg::item_t    item_r;
  logic                 item_v_r;
  i2cseq_pkg::res_t     res;
  i2cseq_pkg::res_t     res_r;
  logic                 out_v_r;
  i2cseq_pkg::buf_req_t buf_req;
  logic [7:0]           tx_data;
  logic                 adv;

  assign adv      = item_v_r && (!out_v_r || out_ready);
  assign in_ready = !item_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode           <= in_mode;
      item_r.transfer_kind  <= in_transfer_kind;
      item_r.device_address <= in_device_address;
      item_r.command_byte   <= in_command_byte;
      item_r.byte_count     <= in_byte_count;
      item_r.bus_event      <= in_bus_event;
      item_r.bus_fault      <= in_bus_fault;
      item_r.data_value     <= in_data_value;
      item_r.load_index     <= in_load_index;
    end
  end

  i2cseq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .item    (item_r),
    .tx_data (tx_data),
    .res     (res),
    .buf_req (buf_req)
  );

  i2cseq_txbuf #(
    .TX_DEPTH (TX_DEPTH)
  ) u_txbuf (
    .clk     (clk),
    .req     (buf_req),
    .rd_data (tx_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_action         = res_r.action;
  assign out_bus_byte       = res_r.bus_byte;
  assign out_received_byte  = res_r.received_byte;
  assign out_received_index = res_r.received_index;
  assign out_received_valid = res_r.received_valid;
  assign out_busy_res       = res_r.busy_res;

  a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.received_valid |->
    res_r.action == i2cseq_pkg::ACT_NONE || res_r.action == i2cseq_pkg::ACT_DONE)
    else $error("received byte with unexpected action");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.action == i2cseq_pkg::ACT_ERROR |->
    !res_r.busy_res && !res_r.received_valid && res_r.bus_byte == 8'd0)
    else $error("error result not cleared");

  a_addr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (res_r.action == i2cseq_pkg::ACT_ADDR ||
                res_r.action == i2cseq_pkg::ACT_RSTART) |-> res_r.busy_res)
    else $error("address phase reported not busy");

endmodule

// File: dv/tb_i2c_master_transaction_sequencer_unit.sv
localparam int TX_DEPTH = 256;

class i2cseq_scoreboard;
  i2cseq_pkg::phase_t ph;
  i2cseq_pkg::kind_t  kind_q;
  logic [6:0]         addr_q;
  logic [7:0]         cmd_q;
  logic [7:0]         len_q;
  logic [7:0]         pos_q;
  logic [7:0]         tx_copy [TX_DEPTH];
  i2cseq_pkg::res_t   awaited_actions[$];
  int                 errors;

  function new();
    ph = i2cseq_pkg::PH_IDLE;
    kind_q = i2cseq_pkg::KIND_READ;
    addr_q = '0;
    cmd_q = '0;
    len_q = '0;
    pos_q = '0;
    errors = 0;
  endfunction

  function bit busy();
    return ph != i2cseq_pkg::PH_IDLE;
  endfunction

  function logic [7:0] tx_byte(logic [7:0] pos);
    if (int'(pos) < TX_DEPTH) return tx_copy[pos];
    return 8'h00;
  endfunction

  // work out the action that one accepted request gives
  function void note_request(i2cseq_pkg::item_t req);
    i2cseq_pkg::res_t r;
    logic [2:0]       ev;
    bit               bad;
    r = '0;
    r.action = i2cseq_pkg::ACT_NONE;
    ev = req.bus_event;
    bad = 1'b0;
    case (i2cseq_pkg::mode_t'(req.mode))
      i2cseq_pkg::MODE_LOAD: begin
        if (int'(req.load_index) < TX_DEPTH) tx_copy[req.load_index] = req.data_value;
      end
      i2cseq_pkg::MODE_BEGIN: begin
        if (ph != i2cseq_pkg::PH_IDLE) begin
          bad = 1'b1;
        end else begin
          kind_q = i2cseq_pkg::kind_t'(req.transfer_kind);
          addr_q = req.device_address;
          cmd_q = req.command_byte;
          len_q = req.byte_count;
          pos_q = '0;
          ph = i2cseq_pkg::PH_START;
        end
      end
      i2cseq_pkg::MODE_EVENT: begin
        if (req.bus_fault) begin
          bad = 1'b1;
        end else if (ph == i2cseq_pkg::PH_START && ev == i2cseq_pkg::EV_START_SENT) begin
          r.action = i2cseq_pkg::ACT_ADDR;
          r.bus_byte = {addr_q, kind_q == i2cseq_pkg::KIND_READ};
          ph = i2cseq_pkg::PH_ADDR;
        end else if (((ph == i2cseq_pkg::PH_ADDR && kind_q == i2cseq_pkg::KIND_READ) ||
                      ph == i2cseq_pkg::PH_ADDR2) && ev == i2cseq_pkg::EV_ADDR_ACK_RX) begin
          pos_q = '0;
          if (len_q == 0) begin
            r.action = i2cseq_pkg::ACT_STOP;
            ph = i2cseq_pkg::PH_IDLE;
          end else begin
            ph = i2cseq_pkg::PH_RXDATA;
          end
        end else if (ph == i2cseq_pkg::PH_ADDR && kind_q != i2cseq_pkg::KIND_READ &&
                     ev == i2cseq_pkg::EV_ADDR_ACK_TX) begin
          if (kind_q == i2cseq_pkg::KIND_WRITE) begin
            if (len_q == 0) begin
              r.action = i2cseq_pkg::ACT_STOP;
              ph = i2cseq_pkg::PH_IDLE;
            end else begin
              r.action = i2cseq_pkg::ACT_DATA;
              r.bus_byte = tx_byte(8'd0);
              pos_q = 8'd1;
              ph = i2cseq_pkg::PH_TXDATA;
            end
          end else begin
            r.action = i2cseq_pkg::ACT_DATA;
            r.bus_byte = cmd_q;
            pos_q = '0;
            ph = (kind_q == i2cseq_pkg::KIND_CREAD) ? i2cseq_pkg::PH_CMD :
                                                       i2cseq_pkg::PH_TXDATA;
          end
        end else if (ph == i2cseq_pkg::PH_CMD && ev == i2cseq_pkg::EV_BYTE_DONE) begin
          r.action = i2cseq_pkg::ACT_RSTART;
          ph = i2cseq_pkg::PH_RESTART;
        end else if (ph == i2cseq_pkg::PH_RESTART && ev == i2cseq_pkg::EV_START_SENT) begin
          r.action = i2cseq_pkg::ACT_ADDR;
          r.bus_byte = {addr_q, 1'b1};
          ph = i2cseq_pkg::PH_ADDR2;
        end else if (ph == i2cseq_pkg::PH_RXDATA && ev == i2cseq_pkg::EV_BYTE_RCVD) begin
          r.received_valid = 1'b1;
          r.received_byte = req.data_value;
          r.received_index = pos_q;
          pos_q = pos_q + 8'd1;
          if (pos_q >= len_q) begin
            r.action = i2cseq_pkg::ACT_DONE;
            ph = i2cseq_pkg::PH_IDLE;
          end
        end else if (ph == i2cseq_pkg::PH_TXDATA &&
                     (ev == i2cseq_pkg::EV_TX_EMPTY || ev == i2cseq_pkg::EV_BYTE_DONE)) begin
          if (pos_q < len_q) begin
            r.action = i2cseq_pkg::ACT_DATA;
            r.bus_byte = tx_byte(pos_q);
            pos_q = pos_q + 8'd1;
          end else if (ev == i2cseq_pkg::EV_BYTE_DONE) begin
            r.action = i2cseq_pkg::ACT_DONE;
            ph = i2cseq_pkg::PH_IDLE;
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
    if (bad) begin
      r = '0;
      r.action = i2cseq_pkg::ACT_ERROR;
      ph = i2cseq_pkg::PH_IDLE;
    end
    r.busy_res = (ph != i2cseq_pkg::PH_IDLE);
    awaited_actions.push_back(r);
  endfunction

  function void compare(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [2:0] action, logic [7:0] bus_byte, logic [7:0] rx_byte,
                             logic [7:0] rx_index, logic rx_valid, logic busy);
    i2cseq_pkg::res_t want;
    if (awaited_actions.size() == 0) begin
      $display("%0t unexpected result: expected nothing, got action %0d", $time, action);
      errors++;
      return;
    end
    want = awaited_actions.pop_front();
    compare("action", want.action, action);
    compare("bus_byte", want.bus_byte, bus_byte);
    compare("received_byte", want.received_byte, rx_byte);
    compare("received_index", want.received_index, rx_index);
    compare("received_valid", want.received_valid, rx_valid);
    compare("busy_res", want.busy_res, busy);
  endfunction
endclass

module tb_i2c_master_transaction_sequencer_unit;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 225;
  // event code outside the defined set
  localparam logic [2:0] EV_UNDEFINED = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  logic [1:0] in_transfer_kind;
  logic [6:0] in_device_address;
  logic [7:0] in_command_byte;
  logic [7:0] in_byte_count;
  logic [2:0] in_bus_event;
  logic       in_bus_fault;
  logic [7:0] in_data_value;
  logic [7:0] in_load_index;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_action;
  logic [7:0] out_bus_byte;
  logic [7:0] out_received_byte;
  logic [7:0] out_received_index;
  logic       out_received_valid;
  logic       out_busy_res;

  i2cseq_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_tab [4] = '{0, 54, 0, 10};
  int unsigned stall_tab [4] = '{0, 0, 54, 10};
  bit          hold_req = 1'b0;
  bit          loaded [TX_DEPTH];
  int          requests_sent = 0;
  int          quiet = 0;

  i2c_master_transaction_sequencer_unit #(.TX_DEPTH(TX_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_transfer_kind(in_transfer_kind),
    .in_device_address(in_device_address),
    .in_command_byte(in_command_byte),
    .in_byte_count(in_byte_count),
    .in_bus_event(in_bus_event),
    .in_bus_fault(in_bus_fault),
    .in_data_value(in_data_value),
    .in_load_index(in_load_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_action(out_action),
    .out_bus_byte(out_bus_byte),
    .out_received_byte(out_received_byte),
    .out_received_index(out_received_index),
    .out_received_valid(out_received_valid),
    .out_busy_res(out_busy_res)
  );

  always #5 clk = ~clk;

  function automatic i2cseq_pkg::item_t any_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(i2cseq_pkg::item_t)-1:0];
  endfunction

  function automatic i2cseq_pkg::item_t event_item(logic [2:0] ev);
    i2cseq_pkg::item_t req;
    req = any_item();
    req.mode = i2cseq_pkg::MODE_EVENT;
    req.bus_event = ev;
    req.bus_fault = 1'b0;
    return req;
  endfunction

  function automatic i2cseq_pkg::item_t begin_item(i2cseq_pkg::kind_t kind, logic [6:0] addr,
                                                   logic [7:0] cmd, logic [7:0] cnt);
    i2cseq_pkg::item_t req;
    req = any_item();
    req.mode = i2cseq_pkg::MODE_BEGIN;
    req.transfer_kind = kind;
    req.device_address = addr;
    req.command_byte = cmd;
    req.byte_count = cnt;
    return req;
  endfunction

  function automatic i2cseq_pkg::item_t load_item(logic [7:0] idx, logic [7:0] val);
    i2cseq_pkg::item_t req;
    req = any_item();
    req.mode = i2cseq_pkg::MODE_LOAD;
    req.load_index = idx;
    req.data_value = val;
    return req;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic push_request(input i2cseq_pkg::item_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= req.mode;
    in_transfer_kind <= req.transfer_kind;
    in_device_address <= req.device_address;
    in_command_byte <= req.command_byte;
    in_byte_count <= req.byte_count;
    in_bus_event <= req.bus_event;
    in_bus_fault <= req.bus_fault;
    in_data_value <= req.data_value;
    in_load_index <= req.load_index;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    if (req.mode == i2cseq_pkg::MODE_LOAD) loaded[req.load_index] = 1'b1;
    if (req.mode != i2cseq_pkg::MODE_NOP) requests_sent++;
  endtask

  // fill any transmit position a write could fetch before it is begun
  task automatic send(input i2cseq_pkg::item_t req);
    if (req.mode == i2cseq_pkg::MODE_BEGIN &&
        (req.transfer_kind == i2cseq_pkg::KIND_WRITE ||
         req.transfer_kind == i2cseq_pkg::KIND_CWRITE)) begin
      for (int i = 0; i < req.byte_count; i++)
        if (!loaded[i]) push_request(load_item(8'(i), 8'($urandom)));
    end
    push_request(req);
  endtask

  task automatic step(input i2cseq_pkg::item_t req, inout bit broken);
    if (broken) return;
    if ($urandom_range(99) < 5) send(load_item(8'($urandom), 8'($urandom)));
    if ($urandom_range(999) < 15) begin
      send(any_item());
      broken = 1'b1;
    end else begin
      send(req);
    end
  endtask

  task automatic run_transfer();
    i2cseq_pkg::item_t req;
    i2cseq_pkg::kind_t kind;
    logic [7:0]        cnt;
    int                rest;
    bit                broken;
    kind = i2cseq_pkg::kind_t'($urandom_range(3));
    cnt = ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
    broken = 1'b0;
    // abort whatever a broken sequence left behind
    if (sb.busy()) begin
      req = event_item(i2cseq_pkg::EV_START_SENT);
      req.bus_fault = 1'b1;
      send(req);
    end
    send(begin_item(kind, 7'($urandom), 8'($urandom), cnt));
    step(event_item(i2cseq_pkg::EV_START_SENT), broken);
    step(event_item(kind == i2cseq_pkg::KIND_READ ? i2cseq_pkg::EV_ADDR_ACK_RX :
                                                    i2cseq_pkg::EV_ADDR_ACK_TX), broken);
    if (kind == i2cseq_pkg::KIND_CREAD) begin
      step(event_item(i2cseq_pkg::EV_BYTE_DONE), broken);
      step(event_item(i2cseq_pkg::EV_START_SENT), broken);
      step(event_item(i2cseq_pkg::EV_ADDR_ACK_RX), broken);
    end
    if (kind == i2cseq_pkg::KIND_READ || kind == i2cseq_pkg::KIND_CREAD) begin
      for (int i = 0; i < cnt; i++) step(event_item(i2cseq_pkg::EV_BYTE_RCVD), broken);
    end else if (!(kind == i2cseq_pkg::KIND_WRITE && cnt == 0)) begin
      rest = (kind == i2cseq_pkg::KIND_WRITE) ? cnt - 1 : cnt;
      for (int i = 0; i < rest; i++)
        step(event_item($urandom_range(1) ? i2cseq_pkg::EV_TX_EMPTY :
                                            i2cseq_pkg::EV_BYTE_DONE), broken);
      if ($urandom_range(3) == 0) step(event_item(i2cseq_pkg::EV_TX_EMPTY), broken);
      step(event_item(i2cseq_pkg::EV_BYTE_DONE), broken);
    end
  endtask

  task automatic directed_checks();
    i2cseq_pkg::item_t req;
    send(load_item(8'd0, 8'hFF));
    // one-byte write, then a transmit empty with nothing left
    send(begin_item(i2cseq_pkg::KIND_WRITE, 7'h7F, 8'h00, 8'd1));
    send(event_item(i2cseq_pkg::EV_START_SENT));
    send(event_item(i2cseq_pkg::EV_ADDR_ACK_TX));
    send(event_item(i2cseq_pkg::EV_TX_EMPTY));
    send(event_item(i2cseq_pkg::EV_BYTE_DONE));
    // zero-length read ends in a stop
    send(begin_item(i2cseq_pkg::KIND_READ, 7'h00, 8'h00, 8'd0));
    send(event_item(i2cseq_pkg::EV_START_SENT));
    send(event_item(i2cseq_pkg::EV_ADDR_ACK_RX));
    send(begin_item(i2cseq_pkg::KIND_CREAD, 7'h55, 8'hFF, 8'd1));
    send(event_item(i2cseq_pkg::EV_START_SENT));
    send(event_item(i2cseq_pkg::EV_ADDR_ACK_TX));
    send(event_item(i2cseq_pkg::EV_BYTE_DONE));
    send(event_item(i2cseq_pkg::EV_START_SENT));
    send(event_item(i2cseq_pkg::EV_ADDR_ACK_RX));
    req = event_item(i2cseq_pkg::EV_BYTE_RCVD);
    req.data_value = 8'hFF;
    send(req);
    send(begin_item(i2cseq_pkg::KIND_CWRITE, 7'h2A, 8'h00, 8'd0));
    send(event_item(i2cseq_pkg::EV_START_SENT));
    send(event_item(i2cseq_pkg::EV_ADDR_ACK_TX));
    send(event_item(i2cseq_pkg::EV_BYTE_DONE));
    // begin while busy
    send(begin_item(i2cseq_pkg::KIND_READ, 7'h11, 8'h22, 8'd3));
    send(begin_item(i2cseq_pkg::KIND_READ, 7'h11, 8'h22, 8'd3));
    req = any_item();
    req.mode = i2cseq_pkg::MODE_NOP;
    send(req);
    send(event_item(EV_UNDEFINED));
    send(begin_item(i2cseq_pkg::KIND_READ, 7'h33, 8'h44, 8'd2));
    req = event_item(i2cseq_pkg::EV_START_SENT);
    req.bus_fault = 1'b1;
    send(req);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_action, out_bus_byte, out_received_byte, out_received_index,
                      out_received_valid, out_busy_res);
  end

  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("i2c_master_transaction_sequencer_unit verification failed");
    $finish;
  end

  initial begin
    int goal;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_transfer_kind = '0;
    in_device_address = '0;
    in_command_byte = '0;
    in_byte_count = '0;
    in_bus_event = '0;
    in_bus_fault = 1'b0;
    in_data_value = '0;
    in_load_index = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed_checks();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      // starve the output early on so the block fills and stalls its input
      if (p == 0) hold_req = 1'b1;
      goal = requests_sent + PHASE_ITEMS;
      while (requests_sent < goal) begin
        if ($urandom_range(99) < 5) send(any_item());
        run_transfer();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    while (sb.awaited_actions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_actions.size() == 0)
      $display("i2c_master_transaction_sequencer_unit verification clean");
    else
      $display("i2c_master_transaction_sequencer_unit verification failed");
    $finish;
  end

endmodule
